FILE: hw/rtl/tqt_pkg.sv
// tqt_pkg: word layouts, codes and fixed widths for the time ordered quota table
// no dependencies; imported by the cell, the top level, the checker and the bench
package tqt_pkg;

    localparam int SIZE_W    = 48;
    localparam int TIME_W    = 32;
    localparam int TOTAL_W   = 52;
    localparam int POS_W     = 4;
    localparam int CNT_OUT_W = 5;

    localparam logic [TOTAL_W-1:0] MAX_TOTAL_RESET = 52'd34359738368;

    // input operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_TRIM   = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    // result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EVICT = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // kinds of wave that run down the row of cells
    localparam logic [1:0] WK_INS = 2'd0;
    localparam logic [1:0] WK_MIN = 2'd1;
    localparam logic [1:0] WK_RD  = 2'd2;

    typedef struct packed {
        logic [1:0]        op;
        logic [SIZE_W-1:0] file_size;
        logic [TIME_W-1:0] mod_time;
        logic [POS_W-1:0]  position;
    } t_in_word;

    typedef struct packed {
        logic [1:0]           status;
        logic [SIZE_W-1:0]    entry_size;
        logic [TIME_W-1:0]    entry_time;
        logic [TOTAL_W-1:0]   total_size;
        logic [CNT_OUT_W-1:0] entry_count;
        logic                 last;
    } t_out_word;

    // wave passed from one cell to the next
    typedef struct packed {
        logic              vld;
        logic [1:0]        kind;
        logic              live;   // insert: still carrying an entry
        logic              flag;   // insert: shifting; min: candidate held
        logic [SIZE_W-1:0] size;
        logic [TIME_W-1:0] tstamp;
    } t_wave;

endpackage

FILE: hw/rtl/tqt_chan_if.sv
// tqt_chan_if: valid/ready channel carrying one word of a given type
// no dependencies; the word type is set where the channel is instantiated
interface tqt_chan_if #(
    parameter type T_DATA = logic
) ();
    logic  valid;
    logic  ready;
    T_DATA data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/tqt_cell.sv
// tqt_cell: one table slot plus one stage of the wave that runs down the row
// depends on tqt_pkg
module tqt_cell import tqt_pkg::*; #(
    parameter int IDX = 0,
    parameter int IW  = 4,
    parameter int CW  = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_wave             i_wave,
    input  logic [IW-1:0]     i_widx,
    input  logic [CW-1:0]     i_count,
    input  logic              i_rm_vld,
    input  logic [IW-1:0]     i_rm_idx,
    input  logic [SIZE_W-1:0] i_nxt_size,
    input  logic [TIME_W-1:0] i_nxt_time,
    output t_wave             o_wave,
    output logic [IW-1:0]     o_widx,
    output logic [SIZE_W-1:0] o_size,
    output logic [TIME_W-1:0] o_time
);

    localparam logic [CW-1:0] IDX_C = CW'(IDX);
    localparam logic [IW-1:0] IDX_I = IW'(IDX);
    localparam bit            FIRST = (IDX == 0);

    logic [SIZE_W-1:0] r_size, n_size;
    logic [TIME_W-1:0] r_time, n_time;
    t_wave             r_wave, n_wave;
    logic [IW-1:0]     r_widx, n_widx;
    logic              w_occ;
    logic              w_here;

    assign w_occ = (IDX_C < i_count);

    // insert lands at the first slot that is free or not earlier;
    // the head slot only gives way to a strictly later time
    assign w_here = !w_occ ||
                    (FIRST ? (r_time > i_wave.tstamp) : (r_time >= i_wave.tstamp));

    // slot update and wave stage
    always_comb begin
        n_size = r_size;
        n_time = r_time;
        n_wave = i_wave;
        n_widx = i_widx;
        if (i_rm_vld && (IDX_I >= i_rm_idx)) begin
            // close the gap left by an eviction
            n_size = i_nxt_size;
            n_time = i_nxt_time;
        end else if (i_wave.vld) begin
            case (i_wave.kind)
                WK_INS: begin
                    if (i_wave.live && (i_wave.flag || w_here)) begin
                        n_size        = i_wave.size;
                        n_time        = i_wave.tstamp;
                        n_wave.size   = r_size;
                        n_wave.tstamp = r_time;
                        n_wave.flag   = 1'b1;
                        n_wave.live   = w_occ;
                    end
                end
                WK_MIN: begin
                    if (w_occ && (!i_wave.flag || (r_size < i_wave.size))) begin
                        n_wave.size   = r_size;
                        n_wave.tstamp = r_time;
                        n_wave.flag   = 1'b1;
                        n_widx        = IDX_I;
                    end
                end
                WK_RD: begin
                    if (i_widx == IDX_I) begin
                        n_wave.size   = r_size;
                        n_wave.tstamp = r_time;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave <= '0;
        end else begin
            r_wave <= n_wave;
        end
        r_size <= n_size;
        r_time <= n_time;
        r_widx <= n_widx;
    end

    assign o_wave = r_wave;
    assign o_widx = r_widx;
    assign o_size = r_size;
    assign o_time = r_time;

endmodule

FILE: hw/rtl/time_ordered_quota_table_top.sv
// time_ordered_quota_table_top: controller and row of DEPTH table cells
// depends on tqt_pkg, tqt_chan_if and tqt_cell
//
// Keeps up to DEPTH (size, timestamp) entries in time order and answers insert,
// trim and read words. Every insert, read and smallest-entry search is a wave
// that moves one cell per cycle down the row of DEPTH cells; an insert or read in
// range gives its result through a pending register once its wave leaves the row. A trim
// gives one eviction result per search, one search per evicted entry, and waits
// on output back-pressure. A refused insert, a read of an empty position, a trim
// with nothing to evict and the unused op code answer from idle with no wave.
// The next word is taken once the block is idle and the output register is free
// or being drained. The user must write max_total through i_cfg_we / i_cfg_data
// only while idle; the block does not check this. No clearing pass after reset.
module time_ordered_quota_table_top import tqt_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [TOTAL_W-1:0] i_cfg_data,
    tqt_chan_if.sink           i_in,
    tqt_chan_if.source         o_out
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WAVE = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic [TOTAL_W-1:0] r_max;
    logic [1:0]         r_kind, n_kind;
    logic [SIZE_W-1:0]  r_isize, n_isize;
    t_wave              r_lw, n_lw;
    logic [IW-1:0]      r_lidx, n_lidx;
    logic               r_rm_vld, n_rm_vld;
    logic [IW-1:0]      r_rm_idx, n_rm_idx;
    t_out_word          r_pend, n_pend;
    logic               r_ovld, n_ovld;
    t_out_word          r_odata, n_odata;

    t_wave              w_wave [DEPTH+1];
    logic [IW-1:0]      w_widx [DEPTH+1];
    logic [SIZE_W-1:0]  w_size [DEPTH];
    logic [TIME_W-1:0]  w_time [DEPTH];

    logic               w_out_free;
    logic               w_in_ready;
    logic               w_acc;
    logic [TOTAL_W:0]   w_sum;
    logic               w_trim_need;
    t_wave              w_exit;
    logic [TOTAL_W-1:0] w_ev_total;
    logic [CW-1:0]      w_ev_count;
    logic               w_load;

    function automatic t_out_word make_word(
        input logic [1:0]         status,
        input logic [SIZE_W-1:0]  size,
        input logic [TIME_W-1:0]  tstamp,
        input logic [TOTAL_W-1:0] total,
        input logic [CW-1:0]      count,
        input logic               last
    );
        t_out_word word;
        word.status      = status;
        word.entry_size  = size;
        word.entry_time  = tstamp;
        word.total_size  = total;
        word.entry_count = CNT_OUT_W'(count);
        word.last        = last;
        return word;
    endfunction

    function automatic t_wave make_wave(
        input logic [1:0]        kind,
        input logic [SIZE_W-1:0] size,
        input logic [TIME_W-1:0] tstamp
    );
        t_wave wave;
        wave.vld    = 1'b1;
        wave.kind   = kind;
        wave.live   = 1'b1;
        wave.flag   = 1'b0;
        wave.size   = size;
        wave.tstamp = tstamp;
        return wave;
    endfunction

    // row of cells
    assign w_wave[0] = r_lw;
    assign w_widx[0] = r_lidx;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [SIZE_W-1:0] w_nsize;
        logic [TIME_W-1:0] w_ntime;
        if (g + 1 < DEPTH) begin : g_mid
            assign w_nsize = w_size[g+1];
            assign w_ntime = w_time[g+1];
        end else begin : g_end
            assign w_nsize = '0;
            assign w_ntime = '0;
        end
        tqt_cell #(
            .IDX (g),
            .IW  (IW),
            .CW  (CW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_wave     (w_wave[g]),
            .i_widx     (w_widx[g]),
            .i_count    (r_count),
            .i_rm_vld   (r_rm_vld),
            .i_rm_idx   (r_rm_idx),
            .i_nxt_size (w_nsize),
            .i_nxt_time (w_ntime),
            .o_wave     (w_wave[g+1]),
            .o_widx     (w_widx[g+1]),
            .o_size     (w_size[g]),
            .o_time     (w_time[g])
        );
    end

    // handshake and arithmetic
    assign w_out_free  = !r_ovld || o_out.ready;
    assign w_in_ready  = (r_state == S_IDLE) && w_out_free;
    assign w_acc       = i_in.valid && w_in_ready;
    assign w_sum       = {1'b0, r_total} + (TOTAL_W+1)'(i_in.data.file_size);
    assign w_trim_need = (r_total > r_max) && (r_count != '0);
    assign w_exit      = w_wave[DEPTH];
    assign w_ev_total  = r_total - TOTAL_W'(w_exit.size);
    assign w_ev_count  = r_count - CW'(1);

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_total  = r_total;
        n_kind   = r_kind;
        n_isize  = r_isize;
        n_lw     = r_lw;
        n_lw.vld = 1'b0;
        n_lidx   = r_lidx;
        n_rm_vld = 1'b0;
        n_rm_idx = r_rm_idx;
        n_pend   = r_pend;
        n_odata  = r_odata;
        w_load   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    case (i_in.data.op)
                        OP_INSERT: begin
                            if ((r_count >= CW'(DEPTH)) || w_sum[TOTAL_W]) begin
                                w_load  = 1'b1;
                                n_odata = make_word(ST_FULL, '0, '0, r_total, r_count, 1'b1);
                            end else begin
                                n_lw    = make_wave(WK_INS, i_in.data.file_size,
                                                    i_in.data.mod_time);
                                n_kind  = WK_INS;
                                n_isize = i_in.data.file_size;
                                n_state = S_WAVE;
                            end
                        end
                        OP_TRIM: begin
                            if (w_trim_need) begin
                                n_lw    = make_wave(WK_MIN, '0, '0);
                                n_kind  = WK_MIN;
                                n_state = S_WAVE;
                            end else begin
                                w_load  = 1'b1;
                                n_odata = make_word(ST_DONE, '0, '0, r_total, r_count, 1'b1);
                            end
                        end
                        OP_READ: begin
                            if ((CW+POS_W)'(i_in.data.position) < (CW+POS_W)'(r_count)) begin
                                n_lw    = make_wave(WK_RD, '0, '0);
                                n_lidx  = IW'(i_in.data.position);
                                n_kind  = WK_RD;
                                n_state = S_WAVE;
                            end else begin
                                w_load  = 1'b1;
                                n_odata = make_word(ST_EMPTY, '0, '0, r_total, r_count, 1'b1);
                            end
                        end
                        default: begin
                            w_load  = 1'b1;
                            n_odata = make_word(ST_DONE, '0, '0, r_total, r_count, 1'b1);
                        end
                    endcase
                end
            end
            S_WAVE: begin
                if (w_exit.vld) begin
                    case (r_kind)
                        WK_INS: begin
                            n_count = r_count + CW'(1);
                            n_total = r_total + TOTAL_W'(r_isize);
                            n_pend  = make_word(ST_DONE, '0, '0, '0, '0, 1'b1);
                        end
                        WK_RD: begin
                            n_pend = make_word(ST_DONE, w_exit.size, w_exit.tstamp,
                                               '0, '0, 1'b1);
                        end
                        default: begin
                            // evict the smallest entry found by the search
                            n_rm_vld = 1'b1;
                            n_rm_idx = w_widx[DEPTH];
                            n_count  = w_ev_count;
                            n_total  = w_ev_total;
                            n_pend   = make_word(ST_EVICT, w_exit.size, w_exit.tstamp,
                                                 '0, '0,
                                                 !((w_ev_total > r_max) &&
                                                   (w_ev_count != '0)));
                        end
                    endcase
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_odata = make_word(r_pend.status, r_pend.entry_size, r_pend.entry_time,
                                        r_total, r_count, r_pend.last);
                    if ((r_kind == WK_MIN) && !r_pend.last) begin
                        n_lw    = make_wave(WK_MIN, '0, '0);
                        n_state = S_WAVE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_ovld = w_load ? 1'b1 : (o_out.ready ? 1'b0 : r_ovld);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_total  <= '0;
            r_max    <= MAX_TOTAL_RESET;
            r_lw     <= '0;
            r_rm_vld <= 1'b0;
            r_ovld   <= 1'b0;
            r_kind   <= WK_INS;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_total  <= n_total;
            if (i_cfg_we) begin
                r_max <= i_cfg_data;
            end
            r_lw     <= n_lw;
            r_rm_vld <= n_rm_vld;
            r_ovld   <= n_ovld;
            r_kind   <= n_kind;
        end
        r_isize  <= n_isize;
        r_lidx   <= n_lidx;
        r_rm_idx <= n_rm_idx;
        r_pend   <= n_pend;
        r_odata  <= n_odata;
    end

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = r_ovld;
    assign o_out.data  = r_odata;

endmodule

FILE: hw/rtl/tqt_checker.sv
// tqt_checker: port-level checks for the time ordered quota table, plus its bind
// depends on tqt_pkg; attaches to time_ordered_quota_table_top
module tqt_checker import tqt_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_word i_out_data
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result word changed while stalled");

    // refusals and empty reads carry no entry
    a_no_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && ((i_out_data.status == ST_FULL) || (i_out_data.status == ST_EMPTY))
        |-> (i_out_data.entry_size == '0) && (i_out_data.entry_time == '0))
        else $error("refused or empty result carries an entry");

    // only evictions can be followed by more results of the same word
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_data.status != ST_EVICT) |-> i_out_data.last)
        else $error("non-eviction result without last");

    // a new word is never taken while a non-final eviction waits
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.last |-> !(i_in_valid && i_in_ready))
        else $error("word accepted during a trim");

endmodule

bind time_ordered_quota_table_top tqt_checker u_tqt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

FILE: sim/time_ordered_quota_table_top_tb.sv
// time_ordered_quota_table_top_tb: self-checking bench for the time ordered quota table
// depends on tqt_pkg, tqt_chan_if and time_ordered_quota_table_top
// mirrors the table in a local predictor and checks every result word against it
module time_ordered_quota_table_top_tb;
    import tqt_pkg::*;

    localparam int DEPTH        = 16;
    localparam int CLK_PERIOD   = 8;
    localparam int LONG_STALL   = 300;
    localparam int TIMEOUT_CYC  = 400000;
    localparam int PHASE_WORDS  = 42;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [TOTAL_W-1:0] TOTAL_ALL_ONES = {TOTAL_W{1'b1}};
    localparam logic [SIZE_W-1:0]  SIZE_ALL_ONES  = {SIZE_W{1'b1}};
    localparam logic [TIME_W-1:0]  TIME_ALL_ONES  = {TIME_W{1'b1}};

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [TOTAL_W-1:0] i_cfg_data;

    tqt_chan_if #(.T_DATA(t_in_word))  word_in ();
    tqt_chan_if #(.T_DATA(t_out_word)) word_out ();

    time_ordered_quota_table_top #(.DEPTH(DEPTH)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (word_in),
        .o_out      (word_out)
    );

    // clock
    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    // shadow copy of the table
    logic [SIZE_W-1:0]    tbl_size [DEPTH];
    logic [TIME_W-1:0]    tbl_time [DEPTH];
    logic [CNT_OUT_W-1:0] tbl_count = '0;
    logic [TOTAL_W-1:0]   tbl_total = '0;
    logic [TOTAL_W-1:0]   quota     = MAX_TOTAL_RESET;

    t_in_word  send_q [$];
    t_out_word pending_results [$];

    int  words_pushed     = 0;
    int  words_taken      = 0;
    int  results_seen     = 0;
    int  evictions        = 0;
    int  refused_inserts  = 0;
    int  mismatches       = 0;
    int  stall_left       = 0;
    bit  long_stall_done  = 1'b0;
    bit  in_fire          = 1'b0;

    function automatic t_out_word make_result(input logic [1:0] status,
                                              input logic [SIZE_W-1:0] size,
                                              input logic [TIME_W-1:0] tstamp,
                                              input logic last);
        t_out_word r;
        r.status      = status;
        r.entry_size  = size;
        r.entry_time  = tstamp;
        r.total_size  = tbl_total;
        r.entry_count = tbl_count;
        r.last        = last;
        return r;
    endfunction

    // apply one accepted word to the shadow table and queue its results
    task automatic table_step(input t_in_word w);
        int                unsigned slot;
        int                unsigned best;
        int                unsigned n;
        int                i;
        logic [TOTAL_W:0]  sum;
        logic [SIZE_W-1:0] es;
        logic [TIME_W-1:0] et;
        case (w.op)
            OP_INSERT: begin
                sum = {1'b0, tbl_total};
                sum = sum + (TOTAL_W+1)'(w.file_size);
                if (tbl_count >= DEPTH || sum[TOTAL_W]) begin
                    pending_results.push_back(make_result(ST_FULL, '0, '0, 1'b1));
                    refused_inserts++;
                end else begin
                    // equal time at the head still lands behind the head
                    if (tbl_count == 0 || tbl_time[0] > w.mod_time) begin
                        slot = 0;
                    end else begin
                        slot = 1;
                        while (slot < tbl_count && tbl_time[slot] < w.mod_time)
                            slot++;
                    end
                    for (i = int'(tbl_count); i > slot; i--) begin
                        tbl_size[i] = tbl_size[i-1];
                        tbl_time[i] = tbl_time[i-1];
                    end
                    tbl_size[slot] = w.file_size;
                    tbl_time[slot] = w.mod_time;
                    tbl_count++;
                    tbl_total = tbl_total + TOTAL_W'(w.file_size);
                    pending_results.push_back(make_result(ST_DONE, '0, '0, 1'b1));
                end
            end
            OP_TRIM: begin
                n = 0;
                while (tbl_total > quota && tbl_count > 0 && n < DEPTH) begin
                    // smallest size, lowest position on ties
                    best = 0;
                    for (i = 1; i < tbl_count; i++)
                        if (tbl_size[i] < tbl_size[best])
                            best = i;
                    es = tbl_size[best];
                    et = tbl_time[best];
                    for (i = best; i + 1 < tbl_count; i++) begin
                        tbl_size[i] = tbl_size[i+1];
                        tbl_time[i] = tbl_time[i+1];
                    end
                    tbl_count--;
                    tbl_total = tbl_total - TOTAL_W'(es);
                    pending_results.push_back(make_result(ST_EVICT, es, et,
                        !(tbl_total > quota && tbl_count > 0)));
                    n++;
                    evictions++;
                end
                if (n == 0)
                    pending_results.push_back(make_result(ST_DONE, '0, '0, 1'b1));
            end
            OP_READ: begin
                if ({1'b0, w.position} < tbl_count)
                    pending_results.push_back(make_result(ST_DONE, tbl_size[w.position],
                                                          tbl_time[w.position], 1'b1));
                else
                    pending_results.push_back(make_result(ST_EMPTY, '0, '0, 1'b1));
            end
            default: begin
                pending_results.push_back(make_result(ST_DONE, '0, '0, 1'b1));
            end
        endcase
    endtask

    function automatic t_in_word make_word(input logic [1:0] op,
                                           input logic [SIZE_W-1:0] size,
                                           input logic [TIME_W-1:0] tstamp,
                                           input logic [POS_W-1:0] pos);
        t_in_word w;
        w.op        = op;
        w.file_size = size;
        w.mod_time  = tstamp;
        w.position  = pos;
        return w;
    endfunction

    // random word: size up to size_bits wide, times narrow to force ties
    function automatic t_in_word random_word(input int size_bits, input bit narrow_times);
        t_in_word    w;
        int          pick;
        int          bits;
        logic [63:0] r64;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            w.op = OP_INSERT;
        else if (pick < 65)
            w.op = OP_TRIM;
        else if (pick < 95)
            w.op = OP_READ;
        else
            w.op = OP_UNUSED;
        bits = $urandom_range(0, size_bits);
        r64  = {$urandom(), $urandom()};
        w.file_size = (bits == 0) ? '0 : (r64[SIZE_W-1:0] >> (SIZE_W - bits));
        if (narrow_times || $urandom_range(0, 3) == 0)
            w.mod_time = $urandom_range(0, 7);
        else
            w.mod_time = $urandom();
        w.position = POS_W'($urandom_range(0, 15));
        return w;
    endfunction

    task automatic queue_word(input t_in_word w);
        send_q.push_back(w);
        words_pushed++;
    endtask

    // wait for every word taken and every result back, then let the block settle
    task automatic wait_drained();
        do @(negedge i_clk);
        while (words_taken != words_pushed || pending_results.size() != 0);
        repeat (DEPTH + 4) @(negedge i_clk);
    endtask

    task automatic write_quota(input logic [TOTAL_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        quota = value;
    endtask

    function automatic bit calm_stretch();
        return words_taken >= 120 && words_taken < 160;
    endfunction

    // input side: accept and predict
    always @(posedge i_clk) begin : take_words
        in_fire = i_rst_n && word_in.valid && word_in.ready;
        if (in_fire) begin
            table_step(word_in.data);
            words_taken++;
        end
    end

    // input driver
    always @(negedge i_clk) begin : drive_words
        if (i_rst_n && (!word_in.valid || in_fire)) begin
            if (send_q.size() != 0 && (calm_stretch() || $urandom_range(0, 99) >= 15)) begin
                word_in.data  <= send_q.pop_front();
                word_in.valid <= 1'b1;
            end else begin
                word_in.valid <= 1'b0;
            end
        end
    end

    // output ready, with one long hold-off while the sender keeps offering
    always @(negedge i_clk) begin : drive_ready
        if (i_rst_n) begin
            if (stall_left > 0) begin
                stall_left--;
                word_out.ready <= 1'b0;
            end else if (!long_stall_done && words_taken >= 40) begin
                long_stall_done = 1'b1;
                stall_left = LONG_STALL;
                word_out.ready <= 1'b0;
            end else begin
                word_out.ready <= calm_stretch() || $urandom_range(0, 99) >= 15;
            end
        end
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin : check_results
        t_out_word want;
        t_out_word got;
        if (i_rst_n && word_out.valid && word_out.ready) begin
            got = word_out.data;
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: result word with nothing pending, actual %p", $time, got);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", 64'(want.status), 64'(got.status));
                check_field("entry_size", 64'(want.entry_size), 64'(got.entry_size));
                check_field("entry_time", 64'(want.entry_time), 64'(got.entry_time));
                check_field("total_size", 64'(want.total_size), 64'(got.total_size));
                check_field("entry_count", 64'(want.entry_count), 64'(got.entry_count));
                check_field("last", 64'(want.last), 64'(got.last));
            end
        end
    end

    // watchdog
    initial begin : watchdog
        #(CLK_PERIOD * TIMEOUT_CYC);
        $display("timeout with %0d words taken of %0d, %0d results pending",
                 words_taken, words_pushed, pending_results.size());
        $display("FAILURE");
        $finish;
    end

    // stimulus
    initial begin : stimulus
        int                 ph;
        int                 k;
        int                 size_bits;
        bit                 narrow;
        logic [TOTAL_W-1:0] q;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_data     = '0;
        word_in.valid  = 1'b0;
        word_in.data   = '0;
        word_out.ready = 1'b0;

        // empty table: read, trim, unused op
        queue_word(make_word(OP_READ, '0, '0, 4'd0));
        queue_word(make_word(OP_TRIM, SIZE_ALL_ONES, TIME_ALL_ONES, 4'd15));
        queue_word(make_word(OP_UNUSED, SIZE_ALL_ONES, TIME_ALL_ONES, 4'd15));
        // fill: extreme sizes and times, equal time at the head, ties
        queue_word(make_word(OP_INSERT, SIZE_ALL_ONES, 32'd100, 4'd0));
        queue_word(make_word(OP_INSERT, '0, '0, 4'd0));
        queue_word(make_word(OP_INSERT, 48'd7, '0, 4'd0));
        queue_word(make_word(OP_INSERT, 48'd1, TIME_ALL_ONES, 4'd0));
        for (k = 0; k < 12; k++)
            queue_word(make_word(OP_INSERT, 48'(k % 4), 32'(k * 40), 4'd0));
        // full table, reads at both ends, trim down to nothing
        queue_word(make_word(OP_INSERT, 48'd5, 32'd5, 4'd0));
        queue_word(make_word(OP_READ, '0, '0, 4'd0));
        queue_word(make_word(OP_READ, '0, '0, 4'd15));
        queue_word(make_word(OP_TRIM, '0, '0, 4'd0));
        queue_word(make_word(OP_READ, '0, '0, 4'd15));
        queue_word(make_word(OP_TRIM, '0, '0, 4'd0));

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // random phases, one quota each; the sender pauses between phases
        for (ph = 0; ph < 5; ph++) begin
            wait_drained();
            case (ph)
                0: begin q = MAX_TOTAL_RESET; size_bits = 36; narrow = 1'b0; end
                1: begin q = '0;              size_bits = 3;  narrow = 1'b1; end
                2: begin q = TOTAL_ALL_ONES;  size_bits = 48; narrow = 1'b0; end
                3: begin
                    q = TOTAL_W'({$urandom(), $urandom()});
                    size_bits = 48;
                    narrow = 1'b0;
                end
                default: begin q = 52'd1000; size_bits = 10; narrow = 1'b0; end
            endcase
            write_quota(q);
            for (k = 0; k < PHASE_WORDS; k++)
                queue_word(random_word(size_bits, narrow));
        end

        wait_drained();
        repeat (DEPTH + 8) @(negedge i_clk);
        $display("covered %0d words and %0d results over five quota settings",
                 words_taken, results_seen);
        $display("including %0d evictions and %0d refused inserts", evictions,
                 refused_inserts);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/tqt_pkg.sv
hw/rtl/tqt_chan_if.sv
hw/rtl/tqt_cell.sv
hw/rtl/time_ordered_quota_table_top.sv
hw/rtl/tqt_checker.sv
sim/time_ordered_quota_table_top_tb.sv
